// ===== rtl/c32d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c32d_pkg: shared types and constants
// Widths, CRC-32C constants, engine state and the engine control/status
// structures used between the top level and the conversion/CRC engine.
// ----------------------------------------------------------------------------
package c32d_pkg;

   localparam int SUM_WIDTH      = 32;
   localparam int CRC_WIDTH      = 32;
   localparam int BYTE_WIDTH     = 8;
   localparam int DIGIT_WIDTH    = 4;
   localparam int NUM_DIGITS     = 10;
   localparam int BCD_WIDTH      = NUM_DIGITS * DIGIT_WIDTH;
   localparam int DCNT_WIDTH     = $clog2(NUM_DIGITS + 1);
   localparam int BIT_CNT_WIDTH  = $clog2(BYTE_WIDTH);
   localparam int CONV_CNT_WIDTH = $clog2(SUM_WIDTH);

   localparam logic [CRC_WIDTH-1:0]      CRC_POLY   = 32'h82F6_3B78;
   localparam logic [CRC_WIDTH-1:0]      CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [CRC_WIDTH-1:0]      CRC_XOROUT = 32'hFFFF_FFFF;
   localparam logic [DIGIT_WIDTH-1:0]    ASCII_ZERO_HI = 4'h3;
   localparam logic [DIGIT_WIDTH-1:0]    DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0]    DIGIT_ADJ     = 4'd3;
   localparam logic [DCNT_WIDTH-1:0]     DIGITS_INIT   = DCNT_WIDTH'(NUM_DIGITS);
   localparam logic [DCNT_WIDTH-1:0]     DIGITS_ONE    = DCNT_WIDTH'(1);
   localparam logic [BIT_CNT_WIDTH-1:0]  BIT_LAST      = BIT_CNT_WIDTH'(BYTE_WIDTH - 1);
   localparam logic [CONV_CNT_WIDTH-1:0] CONV_LAST     = CONV_CNT_WIDTH'(SUM_WIDTH - 1);

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_CONV,
      ENG_SKIP,
      ENG_CRC,
      ENG_HOLD
   } eng_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } eng_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage
`default_nettype wire

// ===== rtl/c32d_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c32d_engine: decimal conversion and CRC-32C engine
// Converts a 32-bit sum to BCD by shift-and-add-3, drops leading zeros, then
// runs reflected CRC-32C one bit per cycle over the ASCII digits.
// ----------------------------------------------------------------------------
module c32d_engine
   import c32d_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eng_ctrl_type         ctrl,
   input  wire logic [SUM_WIDTH-1:0] value,
   output eng_stat_type              stat,
   output logic [CRC_WIDTH-1:0]      crc
);

   eng_state_type              state_ff, state_in;
   logic [SUM_WIDTH-1:0]       bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]       bcd_ff, bcd_in;
   logic [CONV_CNT_WIDTH-1:0]  step_ff, step_in;
   logic [DCNT_WIDTH-1:0]      digits_ff, digits_in;
   logic [BIT_CNT_WIDTH-1:0]   bit_ff, bit_in;
   logic [CRC_WIDTH-1:0]       crc_ff, crc_in;

   logic [BCD_WIDTH-1:0]       bcd_adj;
   logic [BYTE_WIDTH-1:0]      char_w;
   logic [DIGIT_WIDTH-1:0]     top_digit;
   logic                       feedback;
   logic [CRC_WIDTH-1:0]       crc_step;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_ADJ_MIN) begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_ADJ;
         end else begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign char_w    = {ASCII_ZERO_HI, top_digit};
   assign feedback  = crc_ff[0] ^ char_w[bit_ff];
   assign crc_step  = {1'b0, crc_ff[CRC_WIDTH-1:1]} ^ (feedback ? CRC_POLY : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      step_ff   <= step_in;
      digits_ff <= digits_in;
      bit_ff    <= bit_in;
      crc_ff    <= crc_in;
   end

   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      digits_in = digits_ff;
      bit_in    = bit_ff;
      crc_in    = crc_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (ctrl.start) begin
               bin_in   = value;
               bcd_in   = '0;
               step_in  = CONV_LAST;
               state_in = ENG_CONV;
            end
         end
         ENG_CONV: begin
            bcd_in  = {bcd_adj[BCD_WIDTH-2:0], bin_ff[SUM_WIDTH-1]};
            bin_in  = {bin_ff[SUM_WIDTH-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               digits_in = DIGITS_INIT;
               state_in  = ENG_SKIP;
            end
         end
         ENG_SKIP: begin
            // strip leading zeros, always keeping the last digit
            if (top_digit == '0 && digits_ff > DIGITS_ONE) begin
               bcd_in    = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               digits_in = digits_ff - 1'b1;
            end else begin
               crc_in   = CRC_INIT;
               bit_in   = '0;
               state_in = ENG_CRC;
            end
         end
         ENG_CRC: begin
            crc_in = crc_step;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_LAST) begin
               bcd_in    = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               digits_in = digits_ff - 1'b1;
               if (digits_ff == DIGITS_ONE) begin
                  crc_in   = crc_step ^ CRC_XOROUT;
                  state_in = ENG_HOLD;
               end
            end
         end
         ENG_HOLD: begin
            if (ctrl.take) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign stat.idle = (state_ff == ENG_IDLE);
   assign stat.done = (state_ff == ENG_HOLD);
   assign crc       = crc_ff;

endmodule
`default_nettype wire

// ===== rtl/crc32c_of_decimal_byte_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32c_of_decimal_byte_sum: CRC-32C of the decimal text of a byte sum
// Sums the bytes of a block; on the end request emits the CRC-32C of the
// sum's decimal ASCII text together with the sum, then clears the sum.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                   Contents
// req      in   tvalid/tready/tdata     tdata[7:0] data_byte
//                tuser/tlast            tuser byte_valid, tlast end_of_block
// rsp      out  tvalid/tready/tdata     tdata[31:0] checksum, [63:32] byte_total
//
// Requests are taken one per cycle while the engine is idle. A tlast request
// makes the engine busy (D = decimal digits, 1..10): binary-to-BCD conversion,
// zero stripping, bit-serial CRC over the D digits and a hand-over state;
// tready is low meanwhile. The result register lets new requests in while a
// result waits on rsp_tready; a further end request holds the engine until it
// is free. Reset clears the sum and valids.
// ----------------------------------------------------------------------------
module crc32c_of_decimal_byte_sum
   import c32d_pkg::*;
(
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [BYTE_WIDTH-1:0]            req_tdata,  // [7:0] data_byte
   input  wire logic                             req_tuser,  // [0] byte_valid
   input  wire logic                             req_tlast,  // end_of_block
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [CRC_WIDTH+SUM_WIDTH-1:0]        rsp_tdata   // [31:0] checksum,
                                                             // [63:32] byte_total
);

   logic [SUM_WIDTH-1:0]            sum_ff, sum_in;
   logic [SUM_WIDTH-1:0]            total_ff, total_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [CRC_WIDTH+SUM_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [SUM_WIDTH-1:0]  sum_add;
   eng_ctrl_type          eng_ctrl;
   eng_stat_type          eng_stat;
   logic [CRC_WIDTH-1:0]  eng_crc;

   c32d_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctrl  (eng_ctrl),
      .value (sum_add),
      .stat  (eng_stat),
      .crc   (eng_crc)
   );

   assign req_tready = eng_stat.idle;
   assign accept     = req_tvalid && req_tready;
   assign sum_add    = sum_ff + (req_tuser ? SUM_WIDTH'(req_tdata) : '0);

   assign eng_ctrl.start = accept && req_tlast;
   assign eng_ctrl.take  = eng_stat.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      sum_in       = sum_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         if (req_tlast) begin
            total_in = sum_add;
            sum_in   = '0;
         end else begin
            sum_in   = sum_add;
         end
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_ctrl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {total_ff, eng_crc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== test/crc32c_of_decimal_byte_sum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_of_decimal_byte_sum_tb: self-checking bench for the byte-sum CRC
// Streams blocks of bytes into the block and predicts, for every end request,
// the wrapped byte sum and the CRC-32C of its decimal text. Results are
// compared in order, field by field. Both sides idle at random, and one long
// result hold-off lets the block fill up and stall its request side.
// ----------------------------------------------------------------------------
module crc32c_of_decimal_byte_sum_tb;
   import c32d_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_ITEMS    = 1350;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 150;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] checksum;
      logic [SUM_WIDTH-1:0] byte_total;
   } block_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [BYTE_WIDTH-1:0]          req_tdata  = '0;  // [7:0] data_byte
   logic                           req_tuser  = 1'b0; // [0] byte_valid
   logic                           req_tlast  = 1'b0; // end_of_block
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [CRC_WIDTH+SUM_WIDTH-1:0] rsp_tdata;   // [31:0] checksum, [63:32] byte_total

   block_result_type               expected_results_q[$];
   logic [SUM_WIDTH-1:0]           block_sum      = '0;
   int                             items_sent     = 0;
   int                             mismatch_count = 0;
   int                             cycle_count    = 0;
   int                             burst_left     = 0;
   logic                           sender_gapless = 1'b0;
   int                             hold_off_req   = 0;
   int                             hold_off_seen  = 0;
   int                             hold_off_left  = 0;
   logic [15:0]                    stall_pattern  = '0;
   int                             pattern_left   = 0;

   crc32c_of_decimal_byte_sum u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // CRC-32C (reflected) over the sum written as decimal ASCII, MSD first
   function automatic logic [CRC_WIDTH-1:0] decimal_text_crc(input logic [SUM_WIDTH-1:0] value);
      logic [DIGIT_WIDTH-1:0] digits [NUM_DIGITS];
      logic [SUM_WIDTH-1:0]   rest;
      logic [CRC_WIDTH-1:0]   crc;
      int                     count;
      int                     i;
      int                     b;
      rest  = value;
      count = 0;
      do begin
         digits[count] = DIGIT_WIDTH'(rest % 10);
         count++;
         rest = rest / 10;
      end while (rest != 0);
      crc = CRC_INIT;
      for (i = count - 1; i >= 0; i--) begin
         crc ^= {24'h0, ASCII_ZERO_HI, digits[i]};
         for (b = 0; b < BYTE_WIDTH; b++)
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc ^ CRC_XOROUT;
   endfunction

   function automatic void flag_mismatch(input string what, input logic [31:0] expected_value,
                                         input logic [31:0] actual_value);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s expected %08h got %08h",
                  cycle_count, what, expected_value, actual_value);
   endfunction

   // Receiver: own stall pattern, plus a long hold-off on demand
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_req) begin
         hold_off_seen <= hold_off_req;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready    <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'($urandom & $urandom);
            endcase
            pattern_left = 16;
         end
         rsp_tready    <= stall_pattern[0];
         stall_pattern = stall_pattern >> 1;
         pattern_left--;
      end
   end

   // Outputs are looked at mid-cycle; a handshake then lands on the next edge
   always @(negedge clock) begin : check_result
      block_result_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results_q.size() == 0) begin
            flag_mismatch("unexpected result, checksum", '0, rsp_tdata[CRC_WIDTH-1:0]);
         end else begin
            expected = expected_results_q.pop_front();
            if (rsp_tdata[CRC_WIDTH-1:0] !== expected.checksum)
               flag_mismatch("checksum", expected.checksum, rsp_tdata[CRC_WIDTH-1:0]);
            if (rsp_tdata[CRC_WIDTH +: SUM_WIDTH] !== expected.byte_total)
               flag_mismatch("byte_total", expected.byte_total, rsp_tdata[CRC_WIDTH +: SUM_WIDTH]);
         end
      end
   end

   // Entered and left at a rising edge; predicts once the request is taken
   task automatic send_request(input logic [BYTE_WIDTH-1:0] data, input logic byte_valid,
                               input logic end_of_block);
      int   gap;
      logic taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = sender_gapless ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= byte_valid;
      req_tlast  <= end_of_block;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (byte_valid)
         block_sum = block_sum + SUM_WIDTH'(data);
      if (end_of_block) begin
         expected_results_q.push_back('{checksum: decimal_text_crc(block_sum),
                                        byte_total: block_sum});
         block_sum = '0;
      end
      if (byte_valid || end_of_block)
         items_sent++;
   endtask

   task automatic test_directed_cases();
      send_request(8'hA5, 1'b0, 1'b1);   // empty block straight after reset
      send_request(8'h00, 1'b0, 1'b0);   // idle requests change nothing
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);   // zero byte on the end request
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'h08, 1'b1, 1'b1);   // single digit 9
      send_request(8'h09, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);   // 10: carry into a second digit
      repeat (3) send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);   // 1020: inner zero digit
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7F, 1'b1, 1'b0);
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'h55, 1'b0, 1'b1);   // 256 closed by an empty end marker
      send_request(8'h00, 1'b0, 1'b1);
   endtask

   // Results held back long enough that the engine and result register fill
   task automatic test_result_hold_off();
      int blk;
      int i;
      hold_off_req   <= hold_off_req + 1;
      sender_gapless = 1'b1;
      for (blk = 0; blk < 4; blk++) begin
         for (i = 0; i < 8; i++)
            send_request(BYTE_WIDTH'($urandom), 1'b1, 1'b0);
         send_request(BYTE_WIDTH'($urandom), 1'b1, 1'b1);
      end
      sender_gapless = 1'b0;
   endtask

   task automatic test_random_blocks();
      int                    start_count;
      int                    block_len;
      int                    fill_mode;
      int                    i;
      logic [BYTE_WIDTH-1:0] data;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         sender_gapless = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 19))
            18:      block_len = $urandom_range(100, 300);
            14, 15, 16, 17: block_len = $urandom_range(13, 60);
            default: block_len = $urandom_range(0, 12);
         endcase
         fill_mode = $urandom_range(0, 9);
         for (i = 0; i < block_len; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(BYTE_WIDTH'($urandom), 1'b0, 1'b0);
            data = (fill_mode == 0) ? '0 : (fill_mode == 1) ? '1 : BYTE_WIDTH'($urandom);
            send_request(data, 1'b1, 1'b0);
         end
         send_request(BYTE_WIDTH'($urandom), 1'($urandom_range(0, 1)), 1'b1);
         if ($urandom_range(0, 9) == 0)
            send_request(BYTE_WIDTH'($urandom), 1'b0, 1'b1);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_result_hold_off();
      test_random_blocks();
      req_tvalid <= 1'b0;
      while (expected_results_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
